FILE: rtl/quantile_soft_threshold_denoiser_defines.svh
// assertion macros for the quantile soft threshold denoiser
// used by the top level; expects clk and rst_n in scope
`ifndef QUANTILE_SOFT_THRESHOLD_DENOISER_DEFINES_SVH
`define QUANTILE_SOFT_THRESHOLD_DENOISER_DEFINES_SVH
`ifndef SYNTHESIS
`define QSTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qstd check failed");
`define QSTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qstd check failed");
`else
`define QSTD_ASSERT_SAME(label, ante, cons)
`define QSTD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/qstd_pkg.sv
// shared types and constants for the quantile soft threshold denoiser
// no dependencies
package qstd_pkg;

    localparam int DIV_W  = 30;

    localparam logic [14:0] FLOOR_MIN_RST = 15'd0;
    localparam logic [15:0] SHRINK_RST    = 16'd24576;
    localparam logic [14:0] BETA_RST      = 15'd21299;
    localparam logic [15:0] MAX_GAIN_RST  = 16'd32768;

    typedef enum logic [1:0] {
        REG_FLOOR_MIN,
        REG_SHRINK,
        REG_BETA,
        REG_MAX_GAIN
    } reg_index_t;

    typedef struct packed {
        logic load;
        logic seg_clear;
        logic sel_init;
        logic scan;
        logic tally_en;
        logic decide;
        logic thr_load;
        logic peak_en;
        logic div_start;
        logic gain_load;
        logic rd_one;
        logic emit;
    } qstd_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic bit_zero;
        logic div_done;
        logic out_valid;
        logic out_last;
    } qstd_stat_t;

endpackage

FILE: rtl/qstd_div.sv
// restoring divider, one quotient bit per cycle
// depends on qstd_pkg
module qstd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [qstd_pkg::DIV_W-1:0] dividend,
    input  logic [16:0]               divisor,
    output logic                      done,
    output logic [qstd_pkg::DIV_W-1:0] quotient
);
    import qstd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [16:0]       rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [17:0]       shifted;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 17'(shifted - {1'b0, divisor}) : shifted[16:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/qstd_datapath.sv
// sample store, rank select, threshold and emphasis pipeline, gain and output
// depends on qstd_pkg and qstd_div
module qstd_datapath #(
    parameter int MAX_SAMPLES      = 4096,
    parameter int QUANTILE_DIVISOR = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qstd_pkg::qstd_cmd_t    cmd,
    output qstd_pkg::qstd_stat_t   stat,
    input  logic signed [15:0]     sample_in,
    input  logic                   wr_en,
    input  logic [1:0]             wr_index,
    input  logic [15:0]            wr_data,
    output logic                   result_valid,
    output logic signed [15:0]     sample_out,
    output logic                   last_out
);
    import qstd_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int QW = $clog2(QUANTILE_DIVISOR);

    logic signed [15:0] mem [MAX_SAMPLES];

    logic [14:0] floor_min_reg;
    logic [15:0] shrink_reg;
    logic [14:0] beta_reg;
    logic [15:0] max_gain_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] qrank_reg;
    logic [QW-1:0] qrem_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] tally_reg;
    logic [15:0]   prefix_reg;
    logic [3:0]    bit_reg;
    logic [15:0]   ipeak_reg;
    logic [16:0]   opeak_reg;
    logic [16:0]   thr_reg;
    logic [14:0]   hbeta_reg;
    logic [15:0]   gain_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic          out_valid_reg;

    logic signed [15:0] data_reg;
    logic               first1_reg;
    logic               last1_reg;
    logic signed [15:0] s_reg;
    logic signed [15:0] prev_reg;
    logic signed [31:0] prod_reg;
    logic               first2_reg;
    logic               last2_reg;
    logic signed [15:0] raw2_reg;
    logic signed [34:0] mult_reg;
    logic               last3_reg;
    logic signed [15:0] raw3_reg;
    logic signed [15:0] out_reg;
    logic               out_last_reg;

    logic               rd_fire;
    logic               idx_clr;
    logic [15:0]        mag1;
    logic [16:0]        low_mask;
    logic               match;
    logic [15:0]        nf_a;
    logic [14:0]        nf;
    logic [31:0]        thr_sum;
    logic [16:0]        diff1;
    logic signed [15:0] s1;
    logic signed [31:0] rnd_full;
    logic signed [17:0] y2;
    logic [16:0]        ymag2;
    logic signed [34:0] sh4;
    logic signed [15:0] sat4;
    logic               div_done;
    logic [DIV_W-1:0]   quot;

    assign rd_fire = (cmd.scan && idx_reg != count_reg) || cmd.rd_one;
    assign idx_clr = cmd.sel_init || cmd.decide || cmd.thr_load || cmd.gain_load
                     || cmd.seg_clear;

    assign mag1     = data_reg[15] ? 16'(-data_reg) : data_reg;
    assign low_mask = (17'd2 << bit_reg) - 17'd1;
    assign match    = (((mag1 ^ prefix_reg) & ~low_mask[15:0]) == 16'd0) && !mag1[bit_reg];

    assign nf_a    = (prefix_reg < {1'b0, floor_min_reg}) ? {1'b0, floor_min_reg} : prefix_reg;
    assign nf      = nf_a[15] ? 15'h7fff : nf_a[14:0];
    assign thr_sum = ({17'd0, nf} * {16'd0, shrink_reg}) + 32'd8192;

    assign diff1 = ({1'b0, mag1} > thr_reg) ? ({1'b0, mag1} - thr_reg) : 17'd0;
    assign s1    = data_reg[15] ? 16'(-diff1) : 16'(diff1);

    assign rnd_full = (prod_reg + 32'sd16384) >>> 15;
    assign y2       = first2_reg ? 18'(s_reg) : 18'(s_reg) - 18'(rnd_full);
    assign ymag2    = y2[17] ? 17'(-y2) : y2[16:0];

    assign sh4  = (mult_reg + 35'sd8192) >>> 14;
    assign sat4 = (sh4 > 35'sd32767) ? 16'sh7fff :
                  (sh4 < -35'sd32768) ? -16'sh8000 : sh4[15:0];

    qstd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({ipeak_reg, 14'd0}),
        .divisor  (opeak_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < CW'(MAX_SAMPLES))
        begin
            mem[count_reg[AW-1:0]] <= sample_in;
        end
        if (rd_fire)
        begin
            data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_min_reg <= FLOOR_MIN_RST;
            shrink_reg    <= SHRINK_RST;
            beta_reg      <= BETA_RST;
            max_gain_reg  <= MAX_GAIN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_FLOOR_MIN: floor_min_reg <= wr_data[14:0];
                REG_SHRINK:    shrink_reg    <= wr_data;
                REG_BETA:      beta_reg      <= wr_data[14:0];
                REG_MAX_GAIN:  max_gain_reg  <= wr_data;
                default:       floor_min_reg <= floor_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            qrank_reg     <= '0;
            qrem_reg      <= '0;
            idx_reg       <= '0;
            tally_reg     <= '0;
            prefix_reg    <= '0;
            bit_reg       <= '0;
            ipeak_reg     <= '0;
            opeak_reg     <= '0;
            thr_reg       <= '0;
            hbeta_reg     <= '0;
            gain_reg      <= '0;
            prev_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= rd_fire;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg && cmd.emit;

            if (cmd.seg_clear)
            begin
                count_reg <= '0;
                qrank_reg <= '0;
                qrem_reg  <= '0;
            end
            else if (cmd.load && count_reg < CW'(MAX_SAMPLES))
            begin
                count_reg <= count_reg + CW'(1);
                if (qrem_reg == QW'(QUANTILE_DIVISOR - 1))
                begin
                    qrem_reg  <= '0;
                    qrank_reg <= qrank_reg + CW'(1);
                end
                else
                begin
                    qrem_reg <= qrem_reg + QW'(1);
                end
            end
            else if (cmd.decide && !(qrank_reg < tally_reg))
            begin
                qrank_reg <= qrank_reg - tally_reg;
            end

            if (idx_clr)
                idx_reg <= '0;
            else if (rd_fire)
                idx_reg <= idx_reg + CW'(1);

            if (cmd.sel_init)
            begin
                prefix_reg <= '0;
                bit_reg    <= 4'd15;
                tally_reg  <= '0;
                ipeak_reg  <= '0;
            end
            else if (cmd.decide)
            begin
                tally_reg <= '0;
                bit_reg   <= bit_reg - 4'd1;
                if (!(qrank_reg < tally_reg))
                    prefix_reg[bit_reg] <= 1'b1;
            end
            else if (cmd.tally_en && v1_reg)
            begin
                if (match)
                    tally_reg <= tally_reg + CW'(1);
                if (mag1 > ipeak_reg)
                    ipeak_reg <= mag1;
            end

            if (cmd.thr_load)
            begin
                thr_reg   <= thr_sum[30:14];
                hbeta_reg <= beta_reg;
                opeak_reg <= '0;
            end
            else if (cmd.peak_en && v2_reg && ymag2 > opeak_reg)
            begin
                opeak_reg <= ymag2;
            end

            if (cmd.thr_load || cmd.gain_load)
                prev_reg <= '0;
            else if (v1_reg)
                prev_reg <= s1;

            if (cmd.gain_load)
            begin
                if (opeak_reg == 17'd0 || !(quot < DIV_W'(max_gain_reg)))
                    gain_reg <= max_gain_reg;
                else
                    gain_reg <= quot[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            first1_reg <= (idx_reg == '0);
            last1_reg  <= ((idx_reg + CW'(1)) == count_reg);
        end
        if (v1_reg)
        begin
            s_reg      <= s1;
            prod_reg   <= $signed({1'b0, hbeta_reg}) * prev_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            raw2_reg   <= data_reg;
        end
        if (v2_reg)
        begin
            mult_reg  <= y2 * $signed({1'b0, gain_reg});
            last3_reg <= last2_reg;
            raw3_reg  <= raw2_reg;
        end
        if (v3_reg)
        begin
            out_reg      <= (count_reg == CW'(1)) ? raw3_reg : sat4;
            out_last_reg <= last3_reg;
        end
    end

    assign stat.scan_done = (idx_reg == count_reg) && !v1_reg && !v2_reg;
    assign stat.bit_zero  = (bit_reg == 4'd0);
    assign stat.div_done  = div_done;
    assign stat.out_valid = out_valid_reg;
    assign stat.out_last  = out_last_reg;

    assign result_valid = out_valid_reg;
    assign sample_out   = out_reg;
    assign last_out     = out_last_reg;

endmodule

FILE: rtl/qstd_ctrl.sv
// sequencer for loading, rank select passes, gain division and draining
// depends on qstd_pkg
module qstd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  logic                 end_of_segment,
    input  qstd_pkg::qstd_stat_t stat,
    output qstd_pkg::qstd_cmd_t  cmd,
    output logic                 busy
);
    import qstd_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SEL_INIT,
        S_SEL,
        S_DEC,
        S_THR,
        S_OPASS,
        S_DIV,
        S_DIV_WAIT,
        S_DRAIN,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (start && !kind)
                begin
                    cmd.load = 1'b1;
                    if (end_of_segment)
                        state_next = S_SEL_INIT;
                end
            end
            S_SEL_INIT:
            begin
                cmd.sel_init = 1'b1;
                state_next   = S_SEL;
            end
            S_SEL:
            begin
                cmd.scan     = 1'b1;
                cmd.tally_en = 1'b1;
                if (stat.scan_done)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = stat.bit_zero ? S_THR : S_SEL;
            end
            S_THR:
            begin
                cmd.thr_load = 1'b1;
                state_next   = S_OPASS;
            end
            S_OPASS:
            begin
                cmd.scan    = 1'b1;
                cmd.peak_en = 1'b1;
                if (stat.scan_done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.gain_load = 1'b1;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (start && kind)
                begin
                    cmd.rd_one = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.emit = 1'b1;
                if (stat.out_valid)
                begin
                    if (stat.out_last)
                    begin
                        cmd.seg_clear = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    assign busy = !(state_reg == S_LOAD || state_reg == S_DRAIN);

endmodule

FILE: rtl/quantile_soft_threshold_denoiser.sv
// top level of the quantile soft threshold denoiser
// depends on qstd_pkg, qstd_ctrl, qstd_datapath and the defines header
//
// usage: a beat is taken when start is high and busy is low. kind 0 loads
// sample_in into the store; end_of_segment on a load starts processing,
// and busy stays high until the segment is ready to drain. in processing,
// sixteen radix passes over the store pick the noise floor, one pass finds
// the output peak, and a bit-serial divider forms the gain in 30 steps.
// every pass reads the single-port sample store once per cycle.
// kind 1 beats then drain one result each: the result shows on sample_out
// with last_out, marked by a one-cycle result_valid strobe, after passing
// the read, emphasis, gain and output registers; busy is high in between.
// the receiver cannot stall, so a result must be taken in its strobe
// cycle. loads while draining and reads while loading are dropped without
// a result. after the last result the block is back in loading. reset
// returns the block to loading with an empty store and the register
// defaults.
// wr_en, wr_index and wr_data write the configuration registers at once.
`include "quantile_soft_threshold_denoiser_defines.svh"

module quantile_soft_threshold_denoiser #(
    parameter int MAX_SAMPLES      = 4096,
    parameter int QUANTILE_DIVISOR = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic signed [15:0] sample_in,
    input  logic               end_of_segment,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [15:0]        wr_data,
    output logic               result_valid,
    output logic signed [15:0] sample_out,
    output logic               last_out
);
    import qstd_pkg::*;

    qstd_cmd_t  cmd;
    qstd_stat_t stat;
    logic       go;

    assign go = start && !busy;

    qstd_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (go),
        .kind           (kind),
        .end_of_segment (end_of_segment),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy)
    );

    qstd_datapath #(
        .MAX_SAMPLES      (MAX_SAMPLES),
        .QUANTILE_DIVISOR (QUANTILE_DIVISOR)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample_in    (sample_in),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .sample_out   (sample_out),
        .last_out     (last_out)
    );

    `QSTD_ASSERT_SAME(a_result_while_busy, result_valid, busy)
    `QSTD_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)
    `QSTD_ASSERT_NEXT(a_last_frees, result_valid && last_out, !busy)

endmodule
